// ===== rtl/hcs_pkg.sv =====
// ----------------------------------------------------------------------------
// hcs_pkg
// Types and constants shared by the histogram cutoff selector.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int PEAK_FIRST_BIN = 3;
    localparam int PEAK_MIN       = 5;
    localparam int CUT_FLOOR      = 2;
    localparam int CEIL_FLOOR     = 3;
    localparam int CEIL_SHIFT     = 2;
    localparam int MUL_CHUNK      = 32;
    localparam int TOTAL_BITS     = 50;
    localparam int PEAK_BITS      = 10;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] count_value;
    } t_item;

    typedef struct packed {
        logic [31:0]           cutoff;
        logic [PEAK_BITS-1:0]  peak_bin;
        logic [TOTAL_BITS-1:0] solid_total;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_WAIT,
        S_ADD_WR,
        S_PEAK,
        S_VALLEY,
        S_CUT,
        S_TOTAL,
        S_CLEAR
    } t_state;

endpackage

// ===== rtl/histogram_cutoff_selector.sv =====
// ----------------------------------------------------------------------------
// histogram_cutoff_selector
// Bins occurrence counts into a histogram; on finish scans it for the weighted
// peak and valley, picks a cutoff and reports the total at or above it.
// Sample item: a read-modify-write of one bin in the RAM.
// Finish item: peak scan, valley scan, cutoff and total scan to the result
// strobe, NCH = ceil(BIN_BITS/32) multiply steps per bin in the peak scan,
// then a pass clearing all bins before the next item is taken.
// Reset starts a clearing pass over all bins with busy high; results cannot
// be stalled and appear for one cycle on o_done.
// ----------------------------------------------------------------------------
module histogram_cutoff_selector
    import hcs_pkg::*;
#(
    parameter int TOP_BIN  = 1023,
    parameter int BIN_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_item       i_item,
    output logic        o_done,
    output t_result     o_result,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    localparam int AW    = $clog2(TOP_BIN + 1);
    localparam int NCH   = (BIN_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PADW  = NCH * MUL_CHUNK;
    localparam int PRW   = MUL_CHUNK + AW;
    localparam int ACCW  = PADW + AW;
    localparam int PHW   = $clog2(NCH + 3);
    localparam int SW    = ((BIN_BITS > TOTAL_BITS) ? BIN_BITS : TOTAL_BITS) + 1;

    localparam logic [AW-1:0]  LAST_ADDR = AW'(TOP_BIN);
    localparam logic [PHW-1:0] PH_CMP    = PHW'(NCH + 2);
    localparam logic [PHW-1:0] PH_LAST_A = PHW'(NCH + 1);
    localparam logic [PHW-1:0] PH_MUL_HI = PHW'(NCH);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_addr, n_addr;
    logic [PHW-1:0]        r_ph, n_ph;
    logic [PRW-1:0]        r_prod, n_prod;
    logic [ACCW-1:0]       r_acc, n_acc;
    logic [ACCW-1:0]       r_best, n_best;
    logic [AW-1:0]         r_peak, n_peak;
    logic [BIN_BITS-1:0]   r_lowest, n_lowest;
    logic [AW-1:0]         r_valley, n_valley;
    logic [31:0]           r_cut, n_cut;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    logic [31:0]           r_forced;
    logic                  r_done, n_done;
    t_result               r_result, n_result;

    logic                  w_accept;
    logic                  w_last;
    logic [BIN_BITS-1:0]   w_rdata;
    logic [PADW-1:0]       w_pad;
    logic [MUL_CHUNK-1:0]  w_chunk;
    logic                  w_better;
    logic                  w_peak_small;
    logic [AW-1:0]         w_ceil;
    logic [AW-1:0]         w_lo;
    logic [AW-1:0]         w_auto;
    logic [31:0]           w_cut;
    logic                  w_cut_over;
    logic [SW-1:0]         w_sum;
    logic [TOTAL_BITS-1:0] w_sat;
    logic                  w_ram_we;
    logic [BIN_BITS-1:0]   w_ram_wdata;

    hcs_ram #(
        .WIDTH (BIN_BITS),
        .DEPTH (TOP_BIN + 1)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_addr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_last   = (r_addr == LAST_ADDR);
    assign w_pad    = PADW'(w_rdata);

    always_comb begin
        w_chunk = '0;
        for (int k = 0; k < NCH; k++) begin
            if (PHW'(NCH - k) == r_ph) begin
                w_chunk = w_pad[k*MUL_CHUNK +: MUL_CHUNK];
            end
        end
    end

    assign w_better     = (r_acc > r_best);
    assign w_peak_small = (r_peak < AW'(PEAK_MIN));
    assign w_ceil       = ((r_peak >> CEIL_SHIFT) < AW'(CEIL_FLOOR)) ?
                          AW'(CEIL_FLOOR) : (r_peak >> CEIL_SHIFT);
    assign w_lo         = (r_valley < AW'(CUT_FLOOR)) ? AW'(CUT_FLOOR) : r_valley;
    assign w_auto       = w_peak_small ? AW'(CUT_FLOOR) :
                          ((w_lo > w_ceil) ? w_ceil : w_lo);
    assign w_cut        = (r_forced != 32'd0) ? r_forced : 32'(w_auto);
    assign w_cut_over   = (w_cut > 32'(TOP_BIN));
    assign w_sum        = SW'(r_total) + SW'(w_rdata);
    assign w_sat        = (w_sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : w_sum[TOTAL_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_item.kind == KIND_FINISH) ? S_PEAK : S_ADD_WAIT;
                end
            end
            S_ADD_WAIT: n_state = S_ADD_WR;
            S_ADD_WR:   n_state = S_IDLE;
            S_PEAK: begin
                if (r_ph == PH_CMP && w_last) begin
                    n_state = S_VALLEY;
                end
            end
            S_VALLEY: begin
                if (r_ph == '0) begin
                    if (w_peak_small) begin
                        n_state = S_CUT;
                    end
                end else if (r_addr == r_peak - 1'b1) begin
                    n_state = S_CUT;
                end
            end
            S_CUT: n_state = w_cut_over ? S_CLEAR : S_TOTAL;
            S_TOTAL: begin
                if (r_ph != '0 && w_last) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath
    always_comb begin
        n_addr   = r_addr;
        n_ph     = r_ph;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_best   = r_best;
        n_peak   = r_peak;
        n_lowest = r_lowest;
        n_valley = r_valley;
        n_cut    = r_cut;
        n_total  = r_total;
        n_done   = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.kind == KIND_FINISH) begin
                        n_addr = AW'(PEAK_FIRST_BIN);
                        n_ph   = '0;
                        n_best = '0;
                        n_peak = '0;
                    end else if (i_item.count_value >= 32'(TOP_BIN)) begin
                        n_addr = LAST_ADDR;
                    end else begin
                        n_addr = i_item.count_value[AW-1:0];
                    end
                end
            end
            S_PEAK: begin
                if (r_ph != '0 && r_ph <= PH_MUL_HI) begin
                    n_prod = PRW'(w_chunk) * PRW'(r_addr);
                end
                if (r_ph == PHW'(1)) begin
                    n_acc = '0;
                end else if (r_ph != '0 && r_ph <= PH_LAST_A) begin
                    n_acc = (r_acc << MUL_CHUNK) + ACCW'(r_prod);
                end
                if (r_ph == PH_CMP) begin
                    if (w_better) begin
                        n_best = r_acc;
                        n_peak = r_addr;
                    end
                    n_ph = '0;
                    if (w_last) begin
                        n_addr   = AW'(1);
                        n_lowest = '1;
                        n_valley = AW'(1);
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end else begin
                    n_ph = r_ph + 1'b1;
                end
            end
            S_VALLEY: begin
                if (r_ph == '0) begin
                    n_ph = PHW'(1);
                end else begin
                    if (w_rdata < r_lowest) begin
                        n_lowest = w_rdata;
                        n_valley = r_addr;
                    end
                    n_ph   = '0;
                    n_addr = r_addr + 1'b1;
                end
            end
            S_CUT: begin
                n_cut   = w_cut;
                n_total = '0;
                n_ph    = '0;
                if (w_cut_over) begin
                    n_done   = 1'b1;
                    n_result = '{cutoff: w_cut, peak_bin: PEAK_BITS'(r_peak),
                                 solid_total: '0};
                    n_addr   = '0;
                end else begin
                    n_addr = w_cut[AW-1:0];
                end
            end
            S_TOTAL: begin
                if (r_ph == '0) begin
                    n_ph = PHW'(1);
                end else begin
                    n_total = w_sat;
                    n_ph    = '0;
                    if (w_last) begin
                        n_done   = 1'b1;
                        n_result = '{cutoff: r_cut, peak_bin: PEAK_BITS'(r_peak),
                                     solid_total: w_sat};
                        n_addr   = '0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                if (!w_last) begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ram write port
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_wdata = '0;
        case (r_state)
            S_ADD_WR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = (&w_rdata) ? w_rdata : w_rdata + 1'b1;
            end
            S_CLEAR: w_ram_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_ph     <= '0;
            r_done   <= 1'b0;
            r_forced <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_ph    <= n_ph;
            r_done  <= n_done;
            if (i_cfg_wr_en) begin
                r_forced <= i_cfg_wr_data;
            end
        end
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_best   <= n_best;
        r_peak   <= n_peak;
        r_lowest <= n_lowest;
        r_valley <= n_valley;
        r_cut    <= n_cut;
        r_total  <= n_total;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_CLEAR))
        else $error("result strobe outside clearing pass");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_finish_to_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.kind == KIND_FINISH) |=> (r_state == S_PEAK))
        else $error("finish item did not start the peak scan");

    a_auto_cut_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_forced == 32'd0) |->
        (o_result.cutoff >= 32'(CUT_FLOOR) && o_result.cutoff <= 32'(TOP_BIN)))
        else $error("automatic cutoff out of range");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_ADD_WR || r_state == S_CLEAR))
        else $error("bin write outside update or clear");

endmodule

// ===== rtl/hcs_ram.sv =====
// ----------------------------------------------------------------------------
// hcs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hcs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/tb_histogram_cutoff_selector.sv =====
// ----------------------------------------------------------------------------
// tb_histogram_cutoff_selector
// Streams count samples and finish items into the cutoff selector and keeps
// its own histogram. Each finish item is scored against that histogram, or
// given a hand-written result, and queued. Every result strobe is compared
// with the oldest entry. A short table of directed items, some with
// hand-written results, comes first. Random sample sets follow, run at three
// sender idle rates, with the forced cutoff changed between some sets.
// ----------------------------------------------------------------------------
module tb_histogram_cutoff_selector;
    timeunit 1ns;
    timeprecision 1ps;

    import hcs_pkg::*;

    localparam int TOP_BIN  = 1023;
    localparam int BIN_BITS = 40;
    localparam int ROWS     = 25;

    typedef struct {
        logic                  cfg_wr;
        logic [31:0]           cfg_val;
        logic                  kind;
        logic [31:0]           count_value;
        logic                  typed;
        logic [31:0]           cutoff;
        logic [PEAK_BITS-1:0]  peak_bin;
        logic [TOTAL_BITS-1:0] solid_total;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_item       i_item;
    logic        o_done;
    t_result     o_result;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    logic          typed_on;
    t_result       typed_res;

    logic [BIN_BITS-1:0] bin_count [0:TOP_BIN];
    logic [31:0]         forced_cut;
    t_result             pending_cutoffs [$];
    int                  cutoffs_due;
    int                  fails;
    int                  gap_pct;
    int                  items_sent;
    int                  finishes_sent;
    int                  cfg_writes;
    t_result             want;
    t_result             got;
    int                  bin_idx;

    histogram_cutoff_selector #(
        .TOP_BIN  (TOP_BIN),
        .BIN_BITS (BIN_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_item        (i_item),
        .o_done        (o_done),
        .o_result      (o_result),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_result predict_cutoff();
        logic [63:0] best;
        logic [63:0] prod;
        logic [63:0] lowest;
        logic [63:0] total;
        logic [31:0] cut;
        logic [31:0] ceiling;
        int          peak;
        int          valley;
        t_result     r;
        best = '0;
        peak = 0;
        for (int c = PEAK_FIRST_BIN; c <= TOP_BIN; c++) begin
            prod = 64'(bin_count[c]) * 64'(c);
            if (prod > best) begin
                best = prod;
                peak = c;
            end
        end
        if (peak < PEAK_MIN) begin
            cut = CUT_FLOOR;
        end else begin
            lowest = '1;
            valley = 1;
            for (int c = 1; c < peak; c++) begin
                if (64'(bin_count[c]) < lowest) begin
                    lowest = 64'(bin_count[c]);
                    valley = c;
                end
            end
            ceiling = 32'(peak) >> CEIL_SHIFT;
            if (ceiling < CEIL_FLOOR) ceiling = CEIL_FLOOR;
            cut = 32'(valley);
            if (cut < CUT_FLOOR) cut = CUT_FLOOR;
            if (cut > ceiling) cut = ceiling;
        end
        if (forced_cut != 0) cut = forced_cut;
        total = '0;
        for (int c = 0; c <= TOP_BIN; c++) begin
            if (32'(c) >= cut) begin
                total = total + 64'(bin_count[c]);
                if (total > 64'(TOTAL_MAX)) total = 64'(TOTAL_MAX);
            end
        end
        r.cutoff      = cut;
        r.peak_bin    = peak[PEAK_BITS-1:0];
        r.solid_total = total[TOTAL_BITS-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (bin_count[b]) bin_count[b] = '0;
            forced_cut = '0;
            pending_cutoffs.delete();
            cutoffs_due = 0;
        end else begin
            if (o_done === 1'b1) begin
                got = o_result;
                if (pending_cutoffs.size() == 0) begin
                    $error("unexpected result: cutoff %0d peak %0d total %0d",
                           got.cutoff, got.peak_bin, got.solid_total);
                    fails++;
                end else begin
                    want = pending_cutoffs.pop_front();
                    if (got.cutoff !== want.cutoff) begin
                        $error("cutoff: expected %0d, actual %0d", want.cutoff, got.cutoff);
                        fails++;
                    end
                    if (got.peak_bin !== want.peak_bin) begin
                        $error("peak_bin: expected %0d, actual %0d",
                               want.peak_bin, got.peak_bin);
                        fails++;
                    end
                    if (got.solid_total !== want.solid_total) begin
                        $error("solid_total: expected %0d, actual %0d",
                               want.solid_total, got.solid_total);
                        fails++;
                    end
                end
            end
            if (i_cfg_wr_en) forced_cut = i_cfg_wr_data;
            if (i_start && o_busy === 1'b0) begin
                if (i_item.kind == KIND_ADD) begin
                    bin_idx = (i_item.count_value < TOP_BIN) ? int'(i_item.count_value)
                                                             : TOP_BIN;
                    if (bin_count[bin_idx] != '1) bin_count[bin_idx] = bin_count[bin_idx] + 1'b1;
                end else begin
                    want = typed_on ? typed_res : predict_cutoff();
                    pending_cutoffs.push_back(want);
                    foreach (bin_count[b]) bin_count[b] = '0;
                end
            end
            cutoffs_due = pending_cutoffs.size();
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic kind, input logic [31:0] cnt,
                             input logic typed, input t_result res);
        while ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start           <= 1'b1;
        i_item.kind        <= kind;
        i_item.count_value <= cnt;
        typed_on          <= typed;
        typed_res         <= res;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        @(negedge i_clk);
        items_sent++;
        if (kind == KIND_FINISH) finishes_sent++;
    endtask

    task automatic write_forced(input logic [31:0] value);
        i_start <= 1'b0;
        while (cutoffs_due != 0) @(negedge i_clk);
        repeat (TOP_BIN + 16) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        #(64'd30_000_000);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_row        plan [ROWS];
        t_result     res;
        int          n;
        int          center;
        int          phase_items;
        int          phase_sets;
        logic [31:0] cnt;
        logic [31:0] fv;

        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_item        = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        typed_on      = 1'b0;
        typed_res     = '0;
        fails         = 0;
        items_sent    = 0;
        finishes_sent = 0;
        cfg_writes    = 0;
        gap_pct       = 8;

        plan = '{
            '{0, 0,            KIND_FINISH, 0,            1, 2,            0,       0},
            '{0, 0,            KIND_ADD,    0,            0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    1,            0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    2,            0, 0,            0,       0},
            '{0, 0,            KIND_FINISH, 0,            1, 2,            0,       1},
            '{0, 0,            KIND_ADD,    32'hFFFFFFFF, 0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    TOP_BIN,      0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    TOP_BIN - 1,  0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    5,            0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    3,            0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    0,            0, 0,            0,       0},
            '{0, 0,            KIND_FINISH, 32'hFFFFFFFF, 0, 0,            0,       0},
            '{1, 32'hFFFFFFFF, KIND_ADD,    7,            0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    100,          0, 0,            0,       0},
            '{0, 0,            KIND_FINISH, 0,            1, 32'hFFFFFFFF, 100,     0},
            '{1, 1,            KIND_ADD,    1,            0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    6,            0, 0,            0,       0},
            '{0, 0,            KIND_FINISH, 0,            1, 1,            6,       2},
            '{1, TOP_BIN,      KIND_ADD,    4000,         0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    TOP_BIN,      0, 0,            0,       0},
            '{0, 0,            KIND_FINISH, 0,            1, TOP_BIN,      TOP_BIN, 2},
            '{1, 0,            KIND_ADD,    4,            0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    4,            0, 0,            0,       0},
            '{0, 0,            KIND_ADD,    4,            0, 0,            0,       0},
            '{0, 0,            KIND_FINISH, 0,            1, 2,            4,       3}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].cfg_wr) write_forced(plan[r].cfg_val);
            res.cutoff      = plan[r].cutoff;
            res.peak_bin    = plan[r].peak_bin;
            res.solid_total = plan[r].solid_total;
            send_item(plan[r].kind, plan[r].count_value, plan[r].typed, res);
        end

        for (int p = 0; p < 3; p++) begin
            gap_pct     = (p == 0) ? 8 : (p == 1) ? 72 : 0;
            phase_items = 0;
            phase_sets  = 0;
            while (phase_items < 230 || phase_sets < 8) begin
                if ($urandom_range(4) == 0) begin
                    case ($urandom_range(5))
                        0, 1, 2: fv = '0;
                        3:       fv = $urandom_range(1, 40);
                        4:       fv = $urandom_range(TOP_BIN - 3, TOP_BIN + 3);
                        default: fv = $urandom();
                    endcase
                    write_forced(fv);
                end
                n      = ($urandom_range(7) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(0, 30);
                center = $urandom_range(5, 80);
                for (int k = 0; k < n; k++) begin
                    case ($urandom_range(19))
                        0:             cnt = '0;
                        1, 2, 3, 4:    cnt = $urandom_range(1, 4);
                        16:            cnt = $urandom();
                        17:            cnt = $urandom_range(TOP_BIN - 2, TOP_BIN + 2);
                        18:            cnt = $urandom_range(5, 400);
                        19:            cnt = 32'hFFFFFFFF - $urandom_range(0, 3);
                        default:       cnt = center + $urandom_range(0, 8) - 4;
                    endcase
                    send_item(KIND_ADD, cnt, 1'b0, '0);
                end
                send_item(KIND_FINISH, $urandom(), 1'b0, '0);
                phase_items += n + 1;
                phase_sets++;
            end
        end

        i_start <= 1'b0;
        while (cutoffs_due != 0) @(negedge i_clk);
        repeat (TOP_BIN + 16) @(negedge i_clk);

        $display("sent %0d items including %0d finish items, %0d forced cutoff writes",
                 items_sent, finishes_sent, cfg_writes);
        $display("sender idle rates of 8, 72 and 0 percent were covered");
        if (fails == 0 && pending_cutoffs.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hcs_pkg.sv
rtl/hcs_ram.sv
rtl/histogram_cutoff_selector.sv
sim/tb_histogram_cutoff_selector.sv
